@@ src/klt_pkg.sv @@
// Shared types and codes for the keyed lock table.
package klt_pkg;

    typedef enum logic [1:0] {
        KIND_LOCK    = 2'd0,
        KIND_TRYLOCK = 2'd1,
        KIND_UNLOCK  = 2'd2,
        KIND_TEST    = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_GRANTED  = 4'd0,
        ST_QUEUED   = 4'd1,
        ST_BUSY     = 4'd2,
        ST_FULL     = 4'd3,
        ST_NOTFOUND = 4'd4,
        ST_RELEASED = 4'd5,
        ST_HANDOFF  = 4'd6,
        ST_PRESENT  = 4'd7,
        ST_ABSENT   = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_CMP  = 2'd1,
        S_ENC  = 2'd2,
        S_UPD  = 2'd3
    } t_state;

    // One entry of the slot memory.
    typedef struct packed {
        logic       held;
        logic [7:0] users;
    } t_slot_ent;

    // Key store update for one item.
    typedef struct packed {
        logic alloc;
        logic release_slot;
    } t_cam_upd;

    localparam logic [7:0]  USERS_MAX   = 8'hFF;
    localparam logic [7:0]  WAITERS_MAX = 8'hFF;
    localparam logic [15:0] OVF_MAX     = 16'hFFFF;
    localparam int          OUT_IDX_W   = 5;

endpackage

@@ src/klt_enc.sv @@
// Lowest-set-bit priority encoder.
module klt_enc #(
    parameter int N = 32,
    localparam int IW = $clog2(N)
) (
    input  logic [N-1:0]  i_vec,
    output logic          o_any,
    output logic [IW-1:0] o_idx
);

    logic [N-1:0] low_bit;

    // isolate the lowest set bit
    assign low_bit = i_vec & (~i_vec + N'(1));
    assign o_any   = |i_vec;

    always_comb begin
        o_idx = '0;
        for (int i = 0; i < N; i++) begin
            if (low_bit[i]) begin
                o_idx = o_idx | IW'(i);
            end
        end
    end

endmodule

@@ src/klt_cam.sv @@
// Key store with parallel compare, busy flags and match/free encoding.
module klt_cam #(
    parameter int SLOTS = 32,
    localparam int IW = $clog2(SLOTS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmp,
    input  logic [7:0]       i_key_class,
    input  logic [31:0]      i_key_number,
    input  klt_pkg::t_cam_upd i_upd,
    input  logic [IW-1:0]    i_upd_idx,
    output logic             o_hit,
    output logic [IW-1:0]    o_hit_idx,
    output logic             o_free_any,
    output logic [IW-1:0]    o_free_idx
);

    logic [7:0]       r_key_class  [SLOTS];
    logic [31:0]      r_key_number [SLOTS];
    logic [SLOTS-1:0] r_busy;
    logic [SLOTS-1:0] r_match;
    logic [SLOTS-1:0] r_free;
    logic [SLOTS-1:0] n_match;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            n_match[i] = r_busy[i] && (r_key_class[i] == i_key_class) &&
                         (r_key_number[i] == i_key_number);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.alloc) begin
            r_key_class[i_upd_idx]  <= i_key_class;
            r_key_number[i_upd_idx] <= i_key_number;
        end
        if (i_cmp) begin
            r_match <= n_match;
            r_free  <= ~r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else if (i_upd.alloc) begin
            r_busy[i_upd_idx] <= 1'b1;
        end else if (i_upd.release_slot) begin
            r_busy[i_upd_idx] <= 1'b0;
        end
    end

    klt_enc #(.N(SLOTS)) u_hit_enc (
        .i_vec (r_match),
        .o_any (o_hit),
        .o_idx (o_hit_idx)
    );

    klt_enc #(.N(SLOTS)) u_free_enc (
        .i_vec (r_free),
        .o_any (o_free_any),
        .o_idx (o_free_idx)
    );

endmodule

@@ src/klt_ram.sv @@
// Slot memory holding user count and held flag, registered read.
module klt_ram #(
    parameter int SLOTS = 32,
    localparam int IW = $clog2(SLOTS)
) (
    input  logic               i_clk,
    input  logic               i_rd_en,
    input  logic [IW-1:0]      i_rd_addr,
    output klt_pkg::t_slot_ent o_rd_data,
    input  logic               i_wr_en,
    input  logic [IW-1:0]      i_wr_addr,
    input  klt_pkg::t_slot_ent i_wr_data
);

    klt_pkg::t_slot_ent r_mem [SLOTS];
    klt_pkg::t_slot_ent r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/keyed_lock_table_top.sv @@
// Top level of the keyed lock table: sequencer, counters and result register.
//
//  channel   direction  handshake            payload
//  request   in         start & !busy        i_kind, i_lock_class, i_object_number
//  result    out        o_valid (one cycle)  o_status, o_slot, o_wake_slot_waiter,
//                                            o_high_water, o_overflow_events
//
// Sequence: an item passes from acceptance to its result strobe through
// compare against all keys, encode match and lowest free slot while reading
// the slot memory, then update memory, keys and counters. busy is low again
// in the strobe cycle, so the next item can be accepted then and not before.
// Reset: synchronous, active low; clears busy flags, counters and sequencer.
// The slot memory is not cleared: a free slot's entry is fully rewritten when taken.
// The receiver cannot stall; every result is shown for exactly one cycle.
module keyed_lock_table_top #(
    parameter int SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_lock_class,
    input  logic [31:0] i_object_number,
    output logic        o_valid,
    output logic [3:0]  o_status,
    output logic [4:0]  o_slot,
    output logic        o_wake_slot_waiter,
    output logic [4:0]  o_high_water,
    output logic [15:0] o_overflow_events
);

    localparam int IW = $clog2(SLOTS);
    localparam int WW = IW + klt_pkg::OUT_IDX_W;

    klt_pkg::t_state    r_state, n_state;
    klt_pkg::t_kind     r_kind;
    logic [7:0]         r_class;
    logic [31:0]        r_number;
    logic [IW-1:0]      r_idx, n_idx;
    logic               r_hit;
    logic               r_free_any;
    logic [7:0]         r_waiters, n_waiters;
    logic [IW-1:0]      r_high, n_high;
    logic [15:0]        r_ovf, n_ovf;
    logic               r_valid, n_valid;
    klt_pkg::t_status   r_status, n_status;
    logic [IW-1:0]      r_slot, n_slot;
    logic               r_wake, n_wake;

    logic               accept;
    logic               cam_cmp;
    klt_pkg::t_cam_upd  cam_upd;
    logic               hit;
    logic [IW-1:0]      hit_idx;
    logic               free_any;
    logic [IW-1:0]      free_idx;
    logic               ram_rd;
    logic               ram_wr;
    klt_pkg::t_slot_ent ram_rdata;
    klt_pkg::t_slot_ent ram_wdata;
    logic [WW-1:0]      slot_ext;
    logic [WW-1:0]      high_ext;

    assign accept = start && !busy;

    klt_cam #(.SLOTS(SLOTS)) u_cam (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmp        (cam_cmp),
        .i_key_class  (r_class),
        .i_key_number (r_number),
        .i_upd        (cam_upd),
        .i_upd_idx    (r_idx),
        .o_hit        (hit),
        .o_hit_idx    (hit_idx),
        .o_free_any   (free_any),
        .o_free_idx   (free_idx)
    );

    klt_ram #(.SLOTS(SLOTS)) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (ram_rd),
        .i_rd_addr (n_idx),
        .o_rd_data (ram_rdata),
        .i_wr_en   (ram_wr),
        .i_wr_addr (r_idx),
        .i_wr_data (ram_wdata)
    );

    // Next state: one item at a time through compare, encode and update.
    always_comb begin
        n_state = r_state;
        case (r_state)
            klt_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = klt_pkg::S_CMP;
                end
            end
            klt_pkg::S_CMP: n_state = klt_pkg::S_ENC;
            klt_pkg::S_ENC: n_state = klt_pkg::S_UPD;
            klt_pkg::S_UPD: n_state = klt_pkg::S_IDLE;
            default:        n_state = klt_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath decisions per state.
    always_comb begin
        cam_cmp   = 1'b0;
        cam_upd   = '0;
        ram_rd    = 1'b0;
        ram_wr    = 1'b0;
        ram_wdata = ram_rdata;
        n_idx     = hit ? hit_idx : free_idx;
        n_waiters = r_waiters;
        n_high    = r_high;
        n_ovf     = r_ovf;
        n_valid   = 1'b0;
        n_status  = klt_pkg::ST_ABSENT;
        n_slot    = '0;
        n_wake    = 1'b0;
        case (r_state)
            klt_pkg::S_CMP: begin
                cam_cmp = 1'b1;
            end
            klt_pkg::S_ENC: begin
                // read the matching slot, or the lowest free one on a miss
                ram_rd = 1'b1;
            end
            klt_pkg::S_UPD: begin
                n_valid = 1'b1;
                case (r_kind)
                    klt_pkg::KIND_LOCK, klt_pkg::KIND_TRYLOCK: begin
                        if (!r_hit) begin
                            if (!r_free_any) begin
                                // table full: count the event and the waiter
                                n_status = klt_pkg::ST_FULL;
                                if (r_ovf != klt_pkg::OVF_MAX) begin
                                    n_ovf = r_ovf + 16'd1;
                                end
                                if (r_waiters != klt_pkg::WAITERS_MAX) begin
                                    n_waiters = r_waiters + 8'd1;
                                end
                            end else begin
                                // take the free slot, held by its first user
                                cam_upd.alloc   = 1'b1;
                                ram_wr          = 1'b1;
                                ram_wdata.held  = 1'b1;
                                ram_wdata.users = 8'd1;
                                if (r_idx > r_high) begin
                                    n_high = r_idx;
                                end
                                n_status = klt_pkg::ST_GRANTED;
                                n_slot   = r_idx;
                            end
                        end else begin
                            n_slot = r_idx;
                            if (r_kind == klt_pkg::KIND_TRYLOCK ||
                                ram_rdata.users == klt_pkg::USERS_MAX) begin
                                n_status = klt_pkg::ST_BUSY;
                            end else begin
                                ram_wr          = 1'b1;
                                ram_wdata.users = ram_rdata.users + 8'd1;
                                ram_wdata.held  = 1'b1;
                                n_status = ram_rdata.held ? klt_pkg::ST_QUEUED
                                                          : klt_pkg::ST_GRANTED;
                            end
                        end
                    end
                    klt_pkg::KIND_UNLOCK: begin
                        if (!r_hit) begin
                            n_status = klt_pkg::ST_NOTFOUND;
                        end else begin
                            n_slot          = r_idx;
                            ram_wr          = 1'b1;
                            ram_wdata.users = ram_rdata.users - 8'd1;
                            if (ram_rdata.users != 8'd1) begin
                                n_status = klt_pkg::ST_HANDOFF;
                            end else begin
                                // last user gone: free the slot, wake a waiter if one is counted
                                ram_wdata.held       = 1'b0;
                                cam_upd.release_slot = 1'b1;
                                n_status             = klt_pkg::ST_RELEASED;
                                if (r_waiters != 8'd0) begin
                                    n_waiters = r_waiters - 8'd1;
                                    n_wake    = 1'b1;
                                end
                            end
                        end
                    end
                    klt_pkg::KIND_TEST: begin
                        if (r_hit) begin
                            n_status = klt_pkg::ST_PRESENT;
                            n_slot   = r_idx;
                        end
                    end
                    default: n_status = klt_pkg::ST_ABSENT;
                endcase
            end
            default: begin
                cam_cmp = 1'b0;
            end
        endcase
    end

    // Payload registers: capture the item, the lookup and the result.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= klt_pkg::t_kind'(i_kind);
            r_class  <= i_lock_class;
            r_number <= i_object_number;
        end
        if (r_state == klt_pkg::S_ENC) begin
            r_idx      <= n_idx;
            r_hit      <= hit;
            r_free_any <= free_any;
        end
        if (r_state == klt_pkg::S_UPD) begin
            r_status <= n_status;
            r_slot   <= n_slot;
            r_wake   <= n_wake;
        end
    end

    // Control state and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= klt_pkg::S_IDLE;
            r_valid   <= 1'b0;
            r_waiters <= '0;
            r_high    <= '0;
            r_ovf     <= '0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_waiters <= n_waiters;
            r_high    <= n_high;
            r_ovf     <= n_ovf;
        end
    end

    // Slot indices leave as their low five bits.
    assign slot_ext = WW'(r_slot);
    assign high_ext = WW'(r_high);

    assign busy               = (r_state != klt_pkg::S_IDLE);
    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_slot             = slot_ext[klt_pkg::OUT_IDX_W-1:0];
    assign o_wake_slot_waiter = r_wake;
    assign o_high_water       = high_ext[klt_pkg::OUT_IDX_W-1:0];
    assign o_overflow_events  = r_ovf;

endmodule

@@ src/klt_chk.sv @@
// Port-level checker for the keyed lock table, bound to the top level.
module klt_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [3:0]  o_status,
    input logic [4:0]  o_slot
);

    // every accepted item is followed by its result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_valid)
        else $error("result strobe missing after accepted item");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted item");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("busy high while result shown");

    // requests that found no slot report slot zero
    a_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == klt_pkg::ST_FULL || o_status == klt_pkg::ST_NOTFOUND ||
                     o_status == klt_pkg::ST_ABSENT)) |-> (o_slot == 5'd0))
        else $error("slot non-zero on a request without a slot");

endmodule

bind keyed_lock_table_top klt_chk u_klt_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_status (o_status),
    .o_slot   (o_slot)
);
